### rtl/twedt_pkg.sv
// shared types and constants of the time-window event dedup table
package twedt_pkg;

  localparam int unsigned KEY_W    = 64;
  localparam int unsigned TIME_W   = 64;
  localparam int unsigned WINDOW_W = 40;
  localparam int unsigned LIMIT_W  = 7;
  localparam int unsigned COUNT_W  = 32;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_W    = 40;
  localparam int unsigned IN_W     = 128;
  localparam int unsigned OUT_W    = 112;

  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LENGTH = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ENTRY_LIMIT   = 1'd1;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 7'd64;
  localparam logic [COUNT_W-1:0] COUNT_MAX   = 32'hFFFF_FFFF;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_EVICT,
    ST_UPDATE,
    ST_RESULT
  } twedt_state_e;

  typedef struct packed {
    logic           valid;
    logic [KEY_W-1:0]   key;
    logic [TIME_W-1:0]  start;
    logic [COUNT_W-1:0] count;
  } slot_entry_t;

  typedef struct packed {
    logic clr_wr;
    logic load;
    logic scan_rd;
    logic evict_wr;
    logic upd_wr;
    logic out_load;
  } twedt_cmd_t;

  typedef struct packed {
    logic cnt_last;
    logic enabled;
    logic hit;
    logic need_evict;
    logic out_busy;
  } twedt_sts_t;

endpackage

### rtl/twedt_ctrl.sv
// controller state machine of the dedup table
module twedt_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  twedt_pkg::twedt_sts_t sts_i,
  output twedt_pkg::twedt_cmd_t cmd_o
);

  twedt_pkg::twedt_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= twedt_pkg::ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      twedt_pkg::ST_CLEAR: begin
        if (sts_i.cnt_last) state_d = twedt_pkg::ST_IDLE;
      end
      twedt_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          state_d = sts_i.enabled ? twedt_pkg::ST_SCAN : twedt_pkg::ST_RESULT;
        end
      end
      twedt_pkg::ST_SCAN: begin
        if (sts_i.cnt_last) state_d = twedt_pkg::ST_DRAIN;
      end
      twedt_pkg::ST_DRAIN:  state_d = twedt_pkg::ST_EVICT;
      twedt_pkg::ST_EVICT:  state_d = twedt_pkg::ST_UPDATE;
      twedt_pkg::ST_UPDATE: state_d = twedt_pkg::ST_RESULT;
      twedt_pkg::ST_RESULT: begin
        if (!sts_i.out_busy) state_d = twedt_pkg::ST_IDLE;
      end
      default: state_d = twedt_pkg::ST_CLEAR;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      twedt_pkg::ST_CLEAR: cmd_o.clr_wr = 1'b1;
      twedt_pkg::ST_IDLE: begin
        in_ready_o   = 1'b1;
        cmd_o.load   = in_valid_i;
      end
      twedt_pkg::ST_SCAN:   cmd_o.scan_rd  = 1'b1;
      twedt_pkg::ST_DRAIN:  cmd_o          = '0;
      twedt_pkg::ST_EVICT:  cmd_o.evict_wr = !sts_i.hit && sts_i.need_evict;
      twedt_pkg::ST_UPDATE: cmd_o.upd_wr   = 1'b1;
      twedt_pkg::ST_RESULT: cmd_o.out_load = !sts_i.out_busy;
      default:              cmd_o          = '0;
    endcase
  end

endmodule

### rtl/twedt_dp.sv
// datapath of the dedup table: slot memory, scan trackers, counters, output register
module twedt_dp #(
  parameter int unsigned TABLE_DEPTH = 64
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [twedt_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [twedt_pkg::CFG_W-1:0]         cfg_data_i,
  input  logic [twedt_pkg::IN_W-1:0]          in_data_i,
  input  logic                                out_ready_i,
  output logic                                out_valid_o,
  output logic [twedt_pkg::OUT_W-1:0]         out_data_o,
  input  twedt_pkg::twedt_cmd_t               cmd_i,
  output twedt_pkg::twedt_sts_t               sts_o
);

  localparam int unsigned IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned OCC_W = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned CMP_W = (OCC_W > twedt_pkg::LIMIT_W) ? OCC_W : twedt_pkg::LIMIT_W;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);
  localparam logic [CMP_W-1:0] DEPTH_C  = CMP_W'(TABLE_DEPTH);

  twedt_pkg::slot_entry_t mem [TABLE_DEPTH];
  twedt_pkg::slot_entry_t rdata_q;

  logic [twedt_pkg::WINDOW_W-1:0] window_q;
  logic [twedt_pkg::LIMIT_W-1:0]  limit_q;

  logic [IDX_W-1:0]                cnt_q;
  logic                            rd_vld_q;
  logic [IDX_W-1:0]                rd_idx_q;
  logic [twedt_pkg::KEY_W-1:0]     key_q;
  logic [twedt_pkg::TIME_W-1:0]    now_q;

  logic                            hit_q;
  logic [IDX_W-1:0]                hit_idx_q;
  logic [twedt_pkg::TIME_W-1:0]    hit_start_q;
  logic [twedt_pkg::COUNT_W-1:0]   hit_cnt_q;
  logic                            old_found_q;
  logic [IDX_W-1:0]                old_idx_q;
  logic [twedt_pkg::TIME_W-1:0]    old_start_q;
  logic                            free_found_q;
  logic [IDX_W-1:0]                free_idx_q;

  logic                            emit_q;
  logic [twedt_pkg::COUNT_W-1:0]   surf_q;
  logic                            evicted_q;
  logic [twedt_pkg::COUNT_W-1:0]   supp_total_q;
  logic [twedt_pkg::COUNT_W-1:0]   evict_total_q;
  logic [OCC_W-1:0]                occ_q;

  logic                            out_valid_q;
  logic [twedt_pkg::OUT_W-1:0]     out_data_q;

  logic [CMP_W-1:0]                occ_ext;
  logic [CMP_W-1:0]                lim_ext;
  logic [CMP_W-1:0]                lim_eff;
  logic [twedt_pkg::TIME_W:0]      age_diff;
  logic                            in_window;
  logic                            use_old;
  logic                            ins_ok;
  logic [IDX_W-1:0]                ins_idx;

  logic                            wr_en;
  logic [IDX_W-1:0]                wr_addr;
  twedt_pkg::slot_entry_t          wr_data;

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q <= '0;
      limit_q  <= twedt_pkg::LIMIT_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        twedt_pkg::CFG_WINDOW_LENGTH: window_q <= cfg_data_i;
        twedt_pkg::CFG_ENTRY_LIMIT:   limit_q  <= cfg_data_i[twedt_pkg::LIMIT_W-1:0];
        default:                      window_q <= window_q;
      endcase
    end
  end

  assign occ_ext = CMP_W'(occ_q);
  assign lim_ext = CMP_W'(limit_q);
  assign lim_eff = (lim_ext > DEPTH_C) ? DEPTH_C : lim_ext;

  // age check against the hit window, time going backwards counts as age zero
  assign age_diff  = {1'b0, now_q} - {1'b0, hit_start_q};
  assign in_window = age_diff[twedt_pkg::TIME_W] ||
                     (age_diff[twedt_pkg::TIME_W-1:0] <
                      twedt_pkg::TIME_W'(window_q));

  assign use_old = evicted_q && old_found_q && (!free_found_q || (old_idx_q < free_idx_q));
  assign ins_ok  = free_found_q || (evicted_q && old_found_q);
  assign ins_idx = use_old ? old_idx_q : free_idx_q;

  // address counter for clearing and scanning
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cmd_i.load) begin
      cnt_q <= '0;
    end else if (cmd_i.clr_wr || cmd_i.scan_rd) begin
      cnt_q <= (cnt_q == LAST_IDX) ? '0 : cnt_q + 1'b1;
    end
  end

  // write port
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = cnt_q;
    wr_data = '0;
    if (cmd_i.clr_wr) begin
      wr_en = 1'b1;
    end else if (cmd_i.evict_wr) begin
      wr_en   = old_found_q;
      wr_addr = old_idx_q;
    end else if (cmd_i.upd_wr) begin
      if (hit_q) begin
        wr_en         = 1'b1;
        wr_addr       = hit_idx_q;
        wr_data.valid = 1'b1;
        wr_data.key   = key_q;
        if (in_window) begin
          wr_data.start = hit_start_q;
          wr_data.count = (hit_cnt_q == twedt_pkg::COUNT_MAX) ? hit_cnt_q : hit_cnt_q + 1'b1;
        end else begin
          wr_data.start = now_q;
          wr_data.count = '0;
        end
      end else begin
        wr_en         = ins_ok;
        wr_addr       = ins_idx;
        wr_data.valid = 1'b1;
        wr_data.key   = key_q;
        wr_data.start = now_q;
        wr_data.count = '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) mem[wr_addr] <= wr_data;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.scan_rd) rdata_q <= mem[cnt_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_vld_q <= 1'b0;
    end else begin
      rd_vld_q <= cmd_i.scan_rd;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_idx_q <= cnt_q;
    if (cmd_i.load) begin
      key_q <= in_data_i[twedt_pkg::KEY_W-1:0];
      now_q <= in_data_i[twedt_pkg::IN_W-1:twedt_pkg::KEY_W];
    end
  end

  // scan trackers: first key match, oldest valid entry, lowest free slot
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q        <= 1'b0;
      old_found_q  <= 1'b0;
      free_found_q <= 1'b0;
    end else if (cmd_i.load) begin
      hit_q        <= 1'b0;
      old_found_q  <= 1'b0;
      free_found_q <= 1'b0;
    end else if (rd_vld_q) begin
      if (rdata_q.valid && (rdata_q.key == key_q) && !hit_q) hit_q <= 1'b1;
      if (rdata_q.valid) old_found_q <= 1'b1;
      if (!rdata_q.valid) free_found_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_vld_q) begin
      if (rdata_q.valid && (rdata_q.key == key_q) && !hit_q) begin
        hit_idx_q   <= rd_idx_q;
        hit_start_q <= rdata_q.start;
        hit_cnt_q   <= rdata_q.count;
      end
      if (rdata_q.valid && (!old_found_q || (rdata_q.start < old_start_q))) begin
        old_idx_q   <= rd_idx_q;
        old_start_q <= rdata_q.start;
      end
      if (!rdata_q.valid && !free_found_q) free_idx_q <= rd_idx_q;
    end
  end

  // per-word results and running totals
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      emit_q        <= 1'b1;
      surf_q        <= '0;
      evicted_q     <= 1'b0;
      supp_total_q  <= '0;
      evict_total_q <= '0;
      occ_q         <= '0;
    end else begin
      if (cmd_i.load) begin
        emit_q    <= 1'b1;
        surf_q    <= '0;
        evicted_q <= 1'b0;
      end
      if (cmd_i.evict_wr) begin
        evicted_q <= 1'b1;
        if (old_found_q) begin
          evict_total_q <= evict_total_q + 1'b1;
          if (occ_q != '0) occ_q <= occ_q - 1'b1;
        end
      end
      if (cmd_i.upd_wr) begin
        if (hit_q) begin
          if (in_window) begin
            emit_q       <= 1'b0;
            supp_total_q <= supp_total_q + 1'b1;
          end else begin
            surf_q <= hit_cnt_q;
          end
        end else if (ins_ok) begin
          occ_q <= occ_q + 1'b1;
        end
      end
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_data_q <= {7'd0, twedt_pkg::LIMIT_W'(occ_q), evict_total_q, supp_total_q,
                     evicted_q, surf_q, emit_q};
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  assign sts_o.cnt_last   = (cnt_q == LAST_IDX);
  assign sts_o.enabled    = (window_q != '0) && (limit_q != '0);
  assign sts_o.hit        = hit_q;
  assign sts_o.need_evict = (occ_ext >= lim_eff);
  assign sts_o.out_busy   = out_valid_q && !out_ready_i;

endmodule

### rtl/time_window_event_dedup_table.sv
// top level of the time-window event dedup table
//
// input words on s_axis carry an event key and a timestamp; each gives one
// result word on m_axis telling whether to emit the event, the suppressed
// count surfaced when an expired window restarts, whether an entry was
// evicted, the running suppressed and eviction totals and the key occupancy.
// window_length and entry_limit are written through cfg_we_i/cfg_idx_i/
// cfg_data_i while the block is idle; either at zero passes every event.
// while dedup is on, an accepted input word goes through one pass over the slot
// memory, one read per cycle, that finds the key match, the oldest entry and
// the lowest free slot, then a read drain state, the evict and update writes
// and the output load, after which m_axis_tvalid rises; when dedup is off the
// word goes straight to the output load. one word is worked on at a time, so
// the next input word is not accepted until the result has been loaded into
// the output register.
// after reset a clearing pass over the slot memory invalidates every slot
// before s_axis_tready rises. a finished result sits in the output register
// while the next word is accepted and scanned; if the receiver stalls, the
// block holds the following result until the register empties.
module time_window_event_dedup_table #(
  parameter int unsigned TABLE_DEPTH = 64
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [twedt_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [twedt_pkg::CFG_W-1:0]      cfg_data_i,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // event_key[63:0], timestamp[127:64]
  input  logic [twedt_pkg::IN_W-1:0]       s_axis_tdata,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // emit[0], surfaced_count[32:1], evicted[33], suppressed_total[65:34],
  // eviction_total[97:66], occupied_keys[104:98], zero[111:105]
  output logic [twedt_pkg::OUT_W-1:0]      m_axis_tdata
);

  twedt_pkg::twedt_cmd_t cmd;
  twedt_pkg::twedt_sts_t sts;

  twedt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  twedt_dp #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (s_axis_tdata),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_data_o  (m_axis_tdata),
    .cmd_i       (cmd),
    .sts_o       (sts)
  );

endmodule
